@@ design/pcrd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcrd_pkg: shared definitions for the pairwise Canberra rank distance block
// Field widths, register codes and the request and response bundles of the
// shared divider.
// ----------------------------------------------------------------------------
package pcrd_pkg;

  // Default sizes of the rank store
  localparam int unsigned MAX_LISTS_DEF    = 8;
  localparam int unsigned MAX_ELEMENTS_DEF = 64;

  // Fixed field widths
  localparam int unsigned LIST_W    = 3;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned LC_W      = 4;
  localparam int unsigned EC_W      = 7;
  localparam int unsigned TR_W      = 7;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned TOTAL_W   = 29;
  localparam int unsigned CURSOR_W  = 6;
  localparam int unsigned FRAC_BITS = 16;

  // Divider sizes: divisor up to 255, at most 29 quotient bits
  localparam int unsigned DVS_W  = 8;
  localparam int unsigned STEP_W = 5;

  // Reset values of the configuration registers
  localparam logic [LC_W-1:0] LIST_COUNT_RST    = 4'd2;
  localparam logic [EC_W-1:0] ELEMENT_COUNT_RST = 7'd64;
  localparam logic [TR_W-1:0] TRUNCATION_RST    = 7'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIST_COUNT    = 2'd0,
    REG_ELEMENT_COUNT = 2'd1,
    REG_TRUNCATION    = 2'd2
  } cfg_reg_t;

  // Divider request: remainder seed, dividend bits shifted in MSB first
  typedef struct packed {
    logic               start;
    logic [DVS_W-1:0]   rem_init;
    logic [TOTAL_W-1:0] dividend;
    logic [DVS_W-1:0]   divisor;
    logic [STEP_W-1:0]  steps;
  } div_req_t;

  // Divider response: quotient valid while done is high
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [TOTAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/pcrd_rank_store.sv @@
// ----------------------------------------------------------------------------
// pcrd_rank_store: rank list memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module pcrd_rank_store
  import pcrd_pkg::*;
#(
  parameter  int unsigned DEPTH = MAX_LISTS_DEF * MAX_ELEMENTS_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [RANK_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [RANK_W-1:0] rd_data_a,
  output logic [RANK_W-1:0] rd_data_b
);

  logic [RANK_W-1:0] mem [DEPTH];
  logic [RANK_W-1:0] rd_data_a_r;
  logic [RANK_W-1:0] rd_data_b_r;

  // Write the loaded rank, read both lists of the pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

@@ design/pcrd_divider.sv @@
// ----------------------------------------------------------------------------
// pcrd_divider: shared restoring divider
// One quotient bit per cycle; serves the per-position ratios and the mean.
// ----------------------------------------------------------------------------
module pcrd_divider
  import pcrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0]   divisor_r, divisor_nxt;
  logic [TOTAL_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     diff;
  logic               fits;

  // One shift-and-subtract step
  always_comb begin
    trial = {rem_r, quo_r[TOTAL_W-1]};
    diff  = trial - {1'b0, divisor_r};
    fits  = (trial >= {1'b0, divisor_r});
  end

  // Load on start, step while busy, flag the last step
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    quo_nxt     = quo_r;
    if (req.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = req.steps - STEP_W'(1);
      rem_nxt     = req.rem_init;
      divisor_nxt = req.divisor;
      quo_nxt     = req.dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[TOTAL_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
    quo_r     <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A new division never lands on one in flight
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // The final step raises done and drops busy
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start && (cnt_r == '0) |=> done_r && !busy_r)
    else $error("divider missed done after last step");

  // Done marks a finished division only
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a division");

endmodule

@@ design/pcrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcrd_ctrl: load and pairwise pass sequencer
// Stores loaded ranks, walks pairs and positions, feeds the shared divider,
// accumulates distances and drives the result registers.
// ----------------------------------------------------------------------------
module pcrd_ctrl
  import pcrd_pkg::*;
#(
  parameter  int unsigned MAX_LISTS    = MAX_LISTS_DEF,
  parameter  int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  localparam int unsigned DEPTH        = MAX_LISTS * MAX_ELEMENTS,
  localparam int unsigned AW           = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [LIST_W-1:0] in_list_index,
  input  logic [POS_W-1:0]  in_position,
  input  logic [RANK_W-1:0] in_rank,
  input  logic              in_load_done,
  // configuration
  input  logic [LC_W-1:0]   list_count,
  input  logic [EC_W-1:0]   element_count,
  input  logic [TR_W-1:0]   truncation,
  // rank store
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [RANK_W-1:0] wr_data,
  output logic [AW-1:0]     rd_addr_a,
  output logic [AW-1:0]     rd_addr_b,
  input  logic [RANK_W-1:0] rd_data_a,
  input  logic [RANK_W-1:0] rd_data_b,
  // shared divider
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  // result channel
  output logic              out_valid,
  output logic [LIST_W-1:0] out_first_list,
  output logic [LIST_W-1:0] out_second_list,
  output logic [DIST_W-1:0] out_pair_distance,
  output logic [DIST_W-1:0] out_mean_distance,
  output logic              out_last
);

  localparam int unsigned LW = $clog2(MAX_LISTS);
  localparam int unsigned PW = $clog2(MAX_ELEMENTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DIFF,
    ST_DIV,
    ST_PAIR,
    ST_MEAN,
    ST_MEAN_WAIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [LW-1:0]      i_r, i_nxt;
  logic [LW-1:0]      j_r, j_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [LW-1:0]      nl_m1_r, nl_m1_nxt;
  logic [PW-1:0]      ne_m1_r, ne_m1_nxt;
  logic [DVS_W-1:0]   cap_r, cap_nxt;
  logic [DIST_W-1:0]  acc_r, acc_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LIST_W-1:0]  out_first_r, out_first_nxt;
  logic [LIST_W-1:0]  out_second_r, out_second_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [DIST_W-1:0]  out_mean_r, out_mean_nxt;
  logic               out_last_r, out_last_nxt;

  logic [DVS_W-1:0]   a_inc, b_inc;
  logic [DVS_W-1:0]   a_clamp, b_clamp;
  logic [DVS_W-1:0]   rank_diff;
  logic [DVS_W-1:0]   rank_sum;
  logic               last_pair;

  // Store every accepted load item whose address falls inside the store
  always_comb begin
    wr_en   = start && (state_r == ST_IDLE)
              && (32'(in_list_index) < MAX_LISTS)
              && (32'(in_position) < MAX_ELEMENTS);
    wr_addr = AW'(in_list_index) * AW'(MAX_ELEMENTS) + AW'(in_position);
    wr_data = in_rank;
  end

  // Address both lists of the current pair at the current position
  always_comb begin
    rd_addr_a = AW'(i_r) * AW'(MAX_ELEMENTS) + AW'(p_r);
    rd_addr_b = AW'(j_r) * AW'(MAX_ELEMENTS) + AW'(p_r);
  end

  // Clamp both ranks and form the difference and the sum
  always_comb begin
    a_inc     = DVS_W'(rd_data_a) + DVS_W'(1);
    b_inc     = DVS_W'(rd_data_b) + DVS_W'(1);
    a_clamp   = (a_inc <= cap_r) ? a_inc : cap_r;
    b_clamp   = (b_inc <= cap_r) ? b_inc : cap_r;
    rank_diff = (a_clamp > b_clamp) ? (a_clamp - b_clamp) : (b_clamp - a_clamp);
    rank_sum  = a_clamp + b_clamp;
  end

  assign last_pair = (j_r == nl_m1_r) && ((i_r + LW'(1)) == j_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    p_nxt          = p_r;
    nl_m1_nxt      = nl_m1_r;
    ne_m1_nxt      = ne_m1_r;
    cap_nxt        = cap_r;
    acc_nxt        = acc_r;
    total_nxt      = total_r;
    cursor_nxt     = cursor_r;
    out_valid_nxt  = 1'b0;
    out_first_nxt  = out_first_r;
    out_second_nxt = out_second_r;
    out_dist_nxt   = out_dist_r;
    out_mean_nxt   = out_mean_r;
    out_last_nxt   = out_last_r;
    div_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start && in_load_done) begin
          state_nxt = ST_SETUP;
        end
      end

      // Latch the saturated counts and clear the running sums
      ST_SETUP: begin
        if (list_count < LC_W'(2)) begin
          nl_m1_nxt = LW'(1);
        end else if (32'(list_count) > MAX_LISTS) begin
          nl_m1_nxt = LW'(MAX_LISTS - 1);
        end else begin
          nl_m1_nxt = LW'(list_count - LC_W'(1));
        end
        if (element_count == '0) begin
          ne_m1_nxt = '0;
        end else if (32'(element_count) > MAX_ELEMENTS) begin
          ne_m1_nxt = PW'(MAX_ELEMENTS - 1);
        end else begin
          ne_m1_nxt = PW'(element_count - EC_W'(1));
        end
        cap_nxt    = DVS_W'(truncation) + DVS_W'(1);
        i_nxt      = '0;
        j_nxt      = LW'(1);
        p_nxt      = '0;
        acc_nxt    = '0;
        total_nxt  = '0;
        cursor_nxt = '0;
        state_nxt  = ST_READ;
      end

      ST_READ: begin
        state_nxt = ST_DIFF;
      end

      // Launch |a-b| * 2^16 / (a+b)
      ST_DIFF: begin
        div_req.start    = 1'b1;
        div_req.rem_init = rank_diff;
        div_req.dividend = '0;
        div_req.divisor  = rank_sum;
        div_req.steps    = STEP_W'(FRAC_BITS);
        state_nxt        = ST_DIV;
      end

      // Add the ratio, then advance the position or close the pair
      ST_DIV: begin
        if (div_rsp.done) begin
          acc_nxt = acc_r + DIST_W'(div_rsp.quotient[FRAC_BITS-1:0]);
          if (p_r == ne_m1_r) begin
            state_nxt = ST_PAIR;
          end else begin
            p_nxt     = p_r + PW'(1);
            state_nxt = ST_READ;
          end
        end
      end

      ST_PAIR: begin
        total_nxt  = total_r + TOTAL_W'(acc_r);
        cursor_nxt = cursor_r + CURSOR_W'(1);
        if (last_pair) begin
          state_nxt = ST_MEAN;
        end else begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = LIST_W'(i_r);
          out_second_nxt = LIST_W'(j_r);
          out_dist_nxt   = acc_r;
          out_mean_nxt   = '0;
          out_last_nxt   = 1'b0;
          if (j_r == nl_m1_r) begin
            i_nxt = i_r + LW'(1);
            j_nxt = i_r + LW'(2);
          end else begin
            j_nxt = j_r + LW'(1);
          end
          p_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = ST_READ;
        end
      end

      // Launch total / pairs
      ST_MEAN: begin
        div_req.start    = 1'b1;
        div_req.rem_init = '0;
        div_req.dividend = total_r;
        div_req.divisor  = DVS_W'(cursor_r);
        div_req.steps    = STEP_W'(TOTAL_W);
        state_nxt        = ST_MEAN_WAIT;
      end

      // Emit the final pair with the mean
      ST_MEAN_WAIT: begin
        if (div_rsp.done) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = LIST_W'(i_r);
          out_second_nxt = LIST_W'(j_r);
          out_dist_nxt   = acc_r;
          out_mean_nxt   = div_rsp.quotient[DIST_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      i_r         <= '0;
      j_r         <= LW'(1);
      p_r         <= '0;
      total_r     <= '0;
      cursor_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      p_r         <= p_nxt;
      total_r     <= total_nxt;
      cursor_r    <= cursor_nxt;
    end
    nl_m1_r      <= nl_m1_nxt;
    ne_m1_r      <= ne_m1_nxt;
    cap_r        <= cap_nxt;
    acc_r        <= acc_nxt;
    out_first_r  <= out_first_nxt;
    out_second_r <= out_second_nxt;
    out_dist_r   <= out_dist_nxt;
    out_mean_r   <= out_mean_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_first_list    = out_first_r;
  assign out_second_list   = out_second_r;
  assign out_pair_distance = out_dist_r;
  assign out_mean_distance = out_mean_r;
  assign out_last          = out_last_r;

  // An intermediate pair result always resumes the position walk
  a_mid_result_resumes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r == ST_READ)
    else $error("intermediate result without resuming the pass");

  // The final result closes the pass
  a_last_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == ST_IDLE)
    else $error("final result while the pass is still running");

  // Pairs come out in ascending order of list index
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_first_r < out_second_r)
    else $error("pair indexes out of order");

  // Each ratio launch finds the divider working on the next cycle
  a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIFF |=> state_r == ST_DIV && div_rsp.busy)
    else $error("divider not running after launch");

endmodule

@@ design/pairwise_canberra_rank_distance_top.sv @@
// ----------------------------------------------------------------------------
// pairwise_canberra_rank_distance_top: pairwise Canberra distance of rank lists
// Loads top-k rank lists, then gives the Q8.16 distance of every list pair
// and the mean distance on the final pair.
//
//   channel  ports                               handshake
//   -------  ----------------------------------  -----------------------------
//   input    in_list_index in_position in_rank   transfer when start && !busy
//            in_load_done
//   result   out_first_list out_second_list      one-cycle strobe out_valid
//            out_pair_distance out_mean_distance
//            out_last
//   config   cfg_index cfg_data                  write when cfg_we
//
// Load items are taken while idle; a load item with in_load_done starts the pass.
// Each position of a pair reads both ranks and runs a 16-step ratio division on
// the shared divider; the final pair's result waits for the 29-step mean division.
// busy stays high for the whole pass. Results cannot be stalled.
// Reset is synchronous; the rank store holds no reset and is valid once written.
// ----------------------------------------------------------------------------
module pairwise_canberra_rank_distance_top
  import pcrd_pkg::*;
#(
  parameter int unsigned MAX_LISTS    = MAX_LISTS_DEF,
  parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic [LIST_W-1:0]    in_list_index,
  input  logic [POS_W-1:0]     in_position,
  input  logic [RANK_W-1:0]    in_rank,
  input  logic                 in_load_done,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // result channel
  output logic                 out_valid,
  output logic [LIST_W-1:0]    out_first_list,
  output logic [LIST_W-1:0]    out_second_list,
  output logic [DIST_W-1:0]    out_pair_distance,
  output logic [DIST_W-1:0]    out_mean_distance,
  output logic                 out_last
);

  localparam int unsigned DEPTH = MAX_LISTS * MAX_ELEMENTS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [LC_W-1:0]   list_count_r, list_count_nxt;
  logic [EC_W-1:0]   element_count_r, element_count_nxt;
  logic [TR_W-1:0]   truncation_r, truncation_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [RANK_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr_a;
  logic [AW-1:0]     rd_addr_b;
  logic [RANK_W-1:0] rd_data_a;
  logic [RANK_W-1:0] rd_data_b;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Decode configuration writes; drop unknown indexes
  always_comb begin
    list_count_nxt    = list_count_r;
    element_count_nxt = element_count_r;
    truncation_nxt    = truncation_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LIST_COUNT:    list_count_nxt    = cfg_data[LC_W-1:0];
        REG_ELEMENT_COUNT: element_count_nxt = cfg_data[EC_W-1:0];
        REG_TRUNCATION:    truncation_nxt    = cfg_data[TR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_count_r    <= LIST_COUNT_RST;
      element_count_r <= ELEMENT_COUNT_RST;
      truncation_r    <= TRUNCATION_RST;
    end else begin
      list_count_r    <= list_count_nxt;
      element_count_r <= element_count_nxt;
      truncation_r    <= truncation_nxt;
    end
  end

  pcrd_ctrl #(
    .MAX_LISTS    (MAX_LISTS),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_list_index     (in_list_index),
    .in_position       (in_position),
    .in_rank           (in_rank),
    .in_load_done      (in_load_done),
    .list_count        (list_count_r),
    .element_count     (element_count_r),
    .truncation        (truncation_r),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .rd_addr_a         (rd_addr_a),
    .rd_addr_b         (rd_addr_b),
    .rd_data_a         (rd_data_a),
    .rd_data_b         (rd_data_b),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_valid         (out_valid),
    .out_first_list    (out_first_list),
    .out_second_list   (out_second_list),
    .out_pair_distance (out_pair_distance),
    .out_mean_distance (out_mean_distance),
    .out_last          (out_last)
  );

  pcrd_rank_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  pcrd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
